>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Next-cycle implication, always active (used for reset behavior).
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("post-reset check failed");

`endif

>>> rtl/idgdp_pkg.sv
// Package for the int4 group dequant dot product: widths, queue entry and
// status types, accumulator limits. No dependencies.
package idgdp_pkg;

   localparam int LANES       = 8;
   localparam int ACT_W       = 16;
   localparam int NIB_W       = 4;
   localparam int WORD_W      = LANES * NIB_W;
   localparam int PROD_W      = ACT_W + NIB_W;
   localparam int LSUM_W      = PROD_W + 3;
   localparam int SCALE_W     = 24;
   localparam int MUL_W       = LSUM_W + SCALE_W + 1;
   localparam int TERM_W      = 47;
   localparam int ACC_W       = 56;
   localparam int QUEUE_DEPTH = 4;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic signed [LSUM_W-1:0] lane_sum;
      logic [SCALE_W-1:0]       scale;
      logic                     last;
   } lane_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/idgdp_req_if.sv
// Request channel: one packed weight word with its activations and scale.
// Depends on idgdp_pkg.
interface idgdp_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [idgdp_pkg::ACT_W-1:0]         act_0;
   logic signed [idgdp_pkg::ACT_W-1:0]         act_1;
   logic signed [idgdp_pkg::ACT_W-1:0]         act_2;
   logic signed [idgdp_pkg::ACT_W-1:0]         act_3;
   logic signed [idgdp_pkg::ACT_W-1:0]         act_4;
   logic signed [idgdp_pkg::ACT_W-1:0]         act_5;
   logic signed [idgdp_pkg::ACT_W-1:0]         act_6;
   logic signed [idgdp_pkg::ACT_W-1:0]         act_7;
   logic [idgdp_pkg::WORD_W-1:0]               packed_weights;
   logic [idgdp_pkg::SCALE_W-1:0]              group_scale;
   logic                                       row_last;

   modport source (
      output valid, act_0, act_1, act_2, act_3, act_4, act_5, act_6, act_7,
             packed_weights, group_scale, row_last,
      input  ready
   );
   modport sink (
      input  valid, act_0, act_1, act_2, act_3, act_4, act_5, act_6, act_7,
             packed_weights, group_scale, row_last,
      output ready
   );
endinterface

>>> rtl/idgdp_rsp_if.sv
// Response channel: one row dot product, 34 fraction bits.
// Depends on idgdp_pkg.
interface idgdp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [idgdp_pkg::ACC_W-1:0] row_result;

   modport source (output valid, row_result, input ready);
   modport sink (input valid, row_result, output ready);
endinterface

>>> rtl/idgdp_front.sv
// Front end: accepts request beats, registers the eight nibble products and
// reduces them to a lane sum pushed into the queue. Depends on idgdp_pkg.
module idgdp_front (
   input  logic                          clock,
   input  logic                          reset,
   idgdp_req_if.sink                     req_bus,
   input  idgdp_pkg::queue_status_type   q_status,
   output logic                          push,
   output idgdp_pkg::lane_entry_type     push_entry
);

   logic                                  stg_valid_ff;
   logic                                  stg_valid_in;
   logic signed [idgdp_pkg::PROD_W-1:0]   prod_ff [idgdp_pkg::LANES];
   logic signed [idgdp_pkg::PROD_W-1:0]   prod_in [idgdp_pkg::LANES];
   logic [idgdp_pkg::SCALE_W-1:0]         scale_ff;
   logic                                  last_ff;
   logic signed [idgdp_pkg::ACT_W-1:0]    acts [idgdp_pkg::LANES];
   logic signed [idgdp_pkg::PROD_W-1:0]   act_ext [idgdp_pkg::LANES];
   logic signed [idgdp_pkg::PROD_W-1:0]   wgt_ext [idgdp_pkg::LANES];
   logic signed [idgdp_pkg::LSUM_W-1:0]   lane_sum;
   logic                                  accept;

   assign acts[0] = req_bus.act_0;
   assign acts[1] = req_bus.act_1;
   assign acts[2] = req_bus.act_2;
   assign acts[3] = req_bus.act_3;
   assign acts[4] = req_bus.act_4;
   assign acts[5] = req_bus.act_5;
   assign acts[6] = req_bus.act_6;
   assign acts[7] = req_bus.act_7;

   assign req_bus.ready = !stg_valid_ff || !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = stg_valid_ff && !q_status.full;

   always_comb begin
      for (int t = 0; t < idgdp_pkg::LANES; t++) begin
         act_ext[t] = idgdp_pkg::PROD_W'(acts[t]);
         wgt_ext[t] = idgdp_pkg::PROD_W'(
            $signed(req_bus.packed_weights[t*idgdp_pkg::NIB_W +: idgdp_pkg::NIB_W]));
         prod_in[t] = act_ext[t] * wgt_ext[t];
      end
   end

   always_comb begin
      lane_sum = '0;
      for (int t = 0; t < idgdp_pkg::LANES; t++) begin
         lane_sum = lane_sum + idgdp_pkg::LSUM_W'(prod_ff[t]);
      end
   end

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (push) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff  <= prod_in;
         scale_ff <= req_bus.group_scale;
         last_ff  <= req_bus.row_last;
      end
   end

   assign push_entry.lane_sum = lane_sum;
   assign push_entry.scale    = scale_ff;
   assign push_entry.last     = last_ff;

endmodule

>>> rtl/idgdp_queue.sv
// Short first-word-fall-through queue between front and back end.
// Depends on idgdp_pkg.
module idgdp_queue #(
   parameter int DEPTH = idgdp_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  idgdp_pkg::lane_entry_type     push_entry,
   input  logic                          pop,
   output idgdp_pkg::lane_entry_type     pop_entry,
   output idgdp_pkg::queue_status_type   q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   idgdp_pkg::lane_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff;
   logic [PTR_W-1:0]          wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff;
   logic [PTR_W-1:0]          rd_ptr_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      do_push;
   logic                      do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_entry      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/idgdp_back.sv
// Back end: scales each lane sum, accumulates with saturation and holds the
// row result in an output register. Depends on idgdp_pkg.
module idgdp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  idgdp_pkg::lane_entry_type     pop_entry,
   input  idgdp_pkg::queue_status_type   q_status,
   output logic                          pop,
   idgdp_rsp_if.source                   rsp_bus
);

   logic                                 mul_valid_ff;
   logic                                 mul_valid_in;
   logic signed [idgdp_pkg::TERM_W-1:0]  term_ff;
   logic                                 mul_last_ff;
   logic signed [idgdp_pkg::ACC_W-1:0]   acc_ff;
   logic signed [idgdp_pkg::ACC_W-1:0]   acc_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic signed [idgdp_pkg::ACC_W-1:0]   rsp_data_ff;
   logic signed [idgdp_pkg::SCALE_W:0]   scale_s;
   logic signed [idgdp_pkg::MUL_W-1:0]   mul_full;
   logic signed [idgdp_pkg::ACC_W:0]     sum_wide;
   logic signed [idgdp_pkg::ACC_W-1:0]   total;
   logic                                 out_free;
   logic                                 acc_fire;
   logic                                 mul_adv;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign acc_fire = mul_valid_ff && (!mul_last_ff || out_free);
   assign mul_adv  = !mul_valid_ff || acc_fire;
   assign pop      = mul_adv && !q_status.empty;

   assign scale_s  = $signed({1'b0, pop_entry.scale});
   assign mul_full = pop_entry.lane_sum * scale_s;

   assign sum_wide = {acc_ff[idgdp_pkg::ACC_W-1], acc_ff}
                   + (idgdp_pkg::ACC_W + 1)'(term_ff);

   always_comb begin
      total = sum_wide[idgdp_pkg::ACC_W-1:0];
      if (sum_wide[idgdp_pkg::ACC_W] != sum_wide[idgdp_pkg::ACC_W-1]) begin
         total = sum_wide[idgdp_pkg::ACC_W] ? idgdp_pkg::ACC_MIN : idgdp_pkg::ACC_MAX;
      end
   end

   always_comb begin
      mul_valid_in = mul_valid_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (mul_adv) begin
         mul_valid_in = pop;
      end
      if (acc_fire) begin
         acc_in = mul_last_ff ? '0 : total;
      end
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (acc_fire && mul_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         term_ff     <= mul_full[idgdp_pkg::TERM_W-1:0];
         mul_last_ff <= pop_entry.last;
      end
      if (acc_fire && mul_last_ff) begin
         rsp_data_ff <= total;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.row_result = rsp_data_ff;

endmodule

>>> rtl/int4_group_dequant_dot_product.sv
// Top level of the int4 group dequant dot product.
// Depends on idgdp_pkg, idgdp_req_if, idgdp_rsp_if, idgdp_front, idgdp_queue, idgdp_back.
//
//   channel   dir   beat contents
//   req_bus   in    act_0..act_7, packed_weights, group_scale, row_last
//   rsp_bus   out   row_result (one beat per row, on the row_last word)
//
// Sustains one req beat per cycle while the queue is not full; the product stage and queue pace the front.
// After its last word, a row result passes the product register, the queue, the term register and the output register.
// rsp stalls fill the queue (QUEUE_DEPTH entries) before req_ready drops.
// Synchronous reset clears the accumulator, queue and all valid flags.
module int4_group_dequant_dot_product #(
   parameter int QUEUE_DEPTH = idgdp_pkg::QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   idgdp_req_if.sink     req_bus,
   idgdp_rsp_if.source   rsp_bus
);

   logic                          push;
   logic                          pop;
   idgdp_pkg::lane_entry_type     push_entry;
   idgdp_pkg::lane_entry_type     pop_entry;
   idgdp_pkg::queue_status_type   q_status;

   idgdp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   idgdp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   idgdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

>>> rtl/idgdp_checker.sv
// Port-level checks for the dot product top level, bound to it below.
// Depends on assert_macros.svh and idgdp_pkg.
`include "assert_macros.svh"

module idgdp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [idgdp_pkg::ACC_W-1:0] rsp_row_result
);

   `ASSERT_NEXT(rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(rsp_data_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_row_result))
   `ASSERT_NEXT_ALWAYS(rsp_idle_after_reset, clock, reset, !rsp_valid)
   `ASSERT_NEXT_ALWAYS(req_ready_after_reset, clock, reset, req_ready)

endmodule

bind int4_group_dequant_dot_product idgdp_checker u_idgdp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_row_result (rsp_bus.row_result)
);

>>> tb/sv/idgdp_row_checker.sv
`timescale 1ns / 1ps
// Row checker for the int4 group dequant dot product: watches req and rsp beats,
// predicts each row dot product and compares it with the rsp beat.
// Depends on idgdp_pkg, idgdp_req_if and idgdp_rsp_if.
module idgdp_row_checker
   import idgdp_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   idgdp_req_if   req_bus,
   idgdp_rsp_if   rsp_bus,
   output int     fail_count,
   output int     rows_pending
);

   localparam longint ACC_HI = longint'(ACC_MAX);
   localparam longint ACC_LO = longint'(ACC_MIN);

   longint row_sum;
   longint row_sums_due[$];

   function automatic longint word_term(input logic [LANES*ACT_W-1:0] acts,
                                        input logic [WORD_W-1:0] word,
                                        input logic [SCALE_W-1:0] scale);
      longint                  lane_total;
      logic signed [NIB_W-1:0] nib;
      logic signed [ACT_W-1:0] act;
      int                      t;
      lane_total = 0;
      for (t = 0; t < LANES; t++) begin
         nib = word[NIB_W*t +: NIB_W];
         act = acts[ACT_W*t +: ACT_W];
         lane_total += longint'(act) * longint'(nib);
      end
      return lane_total * longint'({1'b0, scale});
   endfunction

   function automatic longint add_clamped(input longint acc, input longint term);
      longint s;
      s = acc + term;
      if (s > ACC_HI) return ACC_HI;
      if (s < ACC_LO) return ACC_LO;
      return s;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] rsp mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      longint total;
      longint want;
      if (reset) begin
         row_sum = 0;
         row_sums_due.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            total = add_clamped(row_sum, word_term(
               {req_bus.act_7, req_bus.act_6, req_bus.act_5, req_bus.act_4,
                req_bus.act_3, req_bus.act_2, req_bus.act_1, req_bus.act_0},
               req_bus.packed_weights, req_bus.group_scale));
            if (req_bus.row_last) begin
               row_sums_due.push_back(total);
               row_sum = 0;
            end else begin
               row_sum = total;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (row_sums_due.size() == 0) begin
               flag_mismatch($sformatf("row_result %0d with no row pending",
                                       rsp_bus.row_result));
            end else begin
               want = row_sums_due.pop_front();
               if (rsp_bus.row_result !== want[ACC_W-1:0])
                  flag_mismatch($sformatf("row_result got %0d want %0d",
                                          rsp_bus.row_result,
                                          $signed(want[ACC_W-1:0])));
            end
         end
      end
      rows_pending = row_sums_due.size();
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the int4 group dequant dot product testbench: clock, reset, req and rsp
// stimulus with random idling, verdict. Depends on idgdp_pkg, the channel
// interfaces, int4_group_dequant_dot_product and idgdp_row_checker.
module testbench;
   import idgdp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SAT_WORDS   = 1100;
   localparam int IDLE_PCT    = 19;

   logic clock = 1'b0;
   logic reset;
   bit   calm;
   int   beats_sent;
   int   cycles;
   int   fail_count;
   int   rows_pending;

   idgdp_req_if req_bus();
   idgdp_rsp_if rsp_bus();

   int4_group_dequant_dot_product DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   idgdp_row_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .fail_count   (fail_count),
      .rows_pending (rows_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic logic [ACT_W-1:0] pick_act();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return '0;
         default: return ACT_W'($urandom);
      endcase
   endfunction

   function automatic logic [LANES*ACT_W-1:0] pick_acts();
      logic [LANES*ACT_W-1:0] acts;
      int                     t;
      for (t = 0; t < LANES; t++) acts[ACT_W*t +: ACT_W] = pick_act();
      return acts;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h8888_8888;
         1: return 32'h7777_7777;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] pick_scale();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 24'h10_0000;
         default: return SCALE_W'($urandom);
      endcase
   endfunction

   // entered at a falling edge, returns at the falling edge after the beat
   task automatic send_word(input logic [LANES*ACT_W-1:0] acts,
                            input logic [WORD_W-1:0] word,
                            input logic [SCALE_W-1:0] scale,
                            input logic last);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.act_0          <= acts[0*ACT_W +: ACT_W];
      req_bus.act_1          <= acts[1*ACT_W +: ACT_W];
      req_bus.act_2          <= acts[2*ACT_W +: ACT_W];
      req_bus.act_3          <= acts[3*ACT_W +: ACT_W];
      req_bus.act_4          <= acts[4*ACT_W +: ACT_W];
      req_bus.act_5          <= acts[5*ACT_W +: ACT_W];
      req_bus.act_6          <= acts[6*ACT_W +: ACT_W];
      req_bus.act_7          <= acts[7*ACT_W +: ACT_W];
      req_bus.packed_weights <= word;
      req_bus.group_scale    <= scale;
      req_bus.row_last       <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // long row of same-sign extreme terms: drives the accumulator into its limit
   task automatic send_saturating_row(input bit upward);
      logic [LANES*ACT_W-1:0] acts;
      logic [WORD_W-1:0]      word;
      int                     n;
      int                     t;
      for (n = 0; n < SAT_WORDS; n++) begin
         for (t = 0; t < LANES; t++) begin
            word[NIB_W*t +: NIB_W] = 4'h8;
            acts[ACT_W*t +: ACT_W] = upward ? 16'h8000 : 16'h7FFF;
         end
         send_word(acts, word, SCALE_W'($urandom_range(24'hFF_FFFF, 24'hFC_0000)), 1'b0);
      end
      send_word(pick_acts(), pick_word(), pick_scale(), 1'b0);
      send_word(pick_acts(), pick_word(), pick_scale(), 1'b1);
   endtask

   initial begin
      logic [LANES*ACT_W-1:0] acts;
      int                     t;
      int                     n;
      int                     row_len;
      int                     pick;
      bit                     sat_done;

      reset                  = 1'b1;
      calm                   = 1'b0;
      req_bus.valid          = 1'b0;
      req_bus.act_0          = '0;
      req_bus.act_1          = '0;
      req_bus.act_2          = '0;
      req_bus.act_3          = '0;
      req_bus.act_4          = '0;
      req_bus.act_5          = '0;
      req_bus.act_6          = '0;
      req_bus.act_7          = '0;
      req_bus.packed_weights = '0;
      req_bus.group_scale    = '0;
      req_bus.row_last       = 1'b0;
      rsp_bus.ready          = 1'b0;
      sat_done               = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, scale zero, one lane at a time, a short row
      send_word('0, '0, '0, 1'b1);
      send_word({LANES{16'h8000}}, 32'h8888_8888, '1, 1'b1);
      send_word({LANES{16'h7FFF}}, 32'h8888_8888, '1, 1'b1);
      send_word({LANES{16'h8000}}, 32'h7777_7777, '1, 1'b1);
      send_word({LANES{16'h7FFF}}, 32'h7777_7777, '1, 1'b1);
      send_word({LANES{16'h7FFF}}, 32'hFFFF_FFFF, '0, 1'b1);
      for (t = 0; t < LANES; t++) begin
         for (n = 0; n < LANES; n++)
            acts[ACT_W*n +: ACT_W] = ACT_W'(1000 * (n + 1) - 5000);
         send_word(acts, WORD_W'(4'h9) << (NIB_W * t), 24'h10_0000, 1'b1);
      end
      for (n = 0; n < 4; n++)
         send_word(pick_acts(), pick_word(), pick_scale(), n == 3);
      send_word({LANES{16'h4000}}, 32'h1111_1111, 24'h00_0001, 1'b1);

      // random rows, mostly short, some past the nominal row length
      while (beats_sent < 2000) begin
         calm = beats_sent >= 400 && beats_sent < 800;
         if (!sat_done && beats_sent >= 800) begin
            send_saturating_row($urandom_range(1) == 1);
            sat_done = 1'b1;
         end else begin
            pick = $urandom_range(99);
            if (pick < 60)      row_len = $urandom_range(4, 1);
            else if (pick < 92) row_len = $urandom_range(64, 5);
            else                row_len = $urandom_range(200, 65);
            for (n = 0; n < row_len; n++)
               send_word(pick_acts(), pick_word(), pick_scale(), n == row_len - 1);
         end
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      while (rows_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && rows_pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
